// ===== rtl/mstc_pkg.sv =====
// Package for the marching-squares tile classifier.
// Holds shared widths, register indexes, the corner accumulator type and the
// index function. It depends on nothing else.
package mstc_pkg;

   // Geometry limits and field widths.
   localparam int MAX_ROW_WIDTH = 256;
   localparam int ROW_COUNT_MAX = 1024;
   localparam int CODE_W        = 8;
   localparam int COL_W         = $clog2(MAX_ROW_WIDTH);
   localparam int ROW_W         = $clog2(ROW_COUNT_MAX);
   localparam int WIDTH_REG_W   = 9;
   localparam int COUNT_REG_W   = 11;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 11;
   localparam int INDEX_W       = 8;
   localparam int NUM_CELLS     = 2;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_WIDTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT = 2'd1;

   // Reset values of the configuration registers.
   localparam logic [WIDTH_REG_W-1:0] ROW_WIDTH_RESET = 9'd64;
   localparam logic [COUNT_REG_W-1:0] ROW_COUNT_RESET = 11'd64;

   // Partial results passed from one corner cell to the next.
   typedef struct packed {
      logic [8:0] half_sum;  // sum of the halved corner codes
      logic [2:0] low_cnt;   // number of corners with the low bit set
      logic [3:0] shape;     // low bits of the halves, filled from the top
   } acc_type;

   // Final marching-squares index from the accumulated corner data.
   function automatic logic [INDEX_W-1:0] classify_index(input acc_type a);
      logic [6:0]         ring;
      logic               saddle;
      logic [INDEX_W-1:0] rowsel;
      ring   = a.half_sum[8:2];
      saddle = (a.low_cnt >= 3'd3);
      rowsel = {ring, saddle};
      // Times 15 as times 16 minus one, kept to eight bits.
      return {rowsel[3:0], 4'b0000} - rowsel + {4'b0000, a.shape}
             - {7'b0000000, ring[0]};
   endfunction

endpackage

// ===== rtl/mstc_line_buffer.sv =====
// One-row line buffer of the tile classifier.
// Single address per item: the old code is read and the new one written in
// the same cycle. Depends on mstc_pkg.
module mstc_line_buffer import mstc_pkg::*; (
   input  logic              clock,
   input  logic              en,
   input  logic [COL_W-1:0]  addr,
   input  logic [CODE_W-1:0] wr_data,
   output logic [CODE_W-1:0] rd_data
);

   logic [CODE_W-1:0] mem [MAX_ROW_WIDTH];
   logic [CODE_W-1:0] rd_data_ff;

   // Read returns the code of the previous row before it is overwritten.
   always_ff @(posedge clock) begin
      if (en) begin
         rd_data_ff <= mem[addr];
         mem[addr]  <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/mstc_corner_cell.sv =====
// One cell of the window chain: holds the code one column to the left in
// its row and adds both corners of that row to the accumulator.
// Depends on mstc_pkg.
module mstc_corner_cell import mstc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              shift_en,
   input  logic [CODE_W-1:0] code_in,
   input  acc_type           acc_in,
   output acc_type           acc_out
);

   logic [CODE_W-1:0] left_ff;
   logic [CODE_W-1:0] left_in;

   // The right corner becomes the left corner when the item moves on.
   assign left_in = shift_en ? code_in : left_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
      end else begin
         left_ff <= left_in;
      end
   end

   // Add this row's two corners; shape bits enter at the top and move down.
   always_comb begin
      acc_out.half_sum = acc_in.half_sum + {2'b00, left_ff[7:1]}
                         + {2'b00, code_in[7:1]};
      acc_out.low_cnt  = acc_in.low_cnt + {2'b00, left_ff[0]}
                         + {2'b00, code_in[0]};
      acc_out.shape    = {code_in[1], left_ff[1], acc_in.shape[3:2]};
   end

endmodule

// ===== rtl/marching_squares_tile_classifier.sv =====
// Marching-squares tile classifier, top level.
// Path: a result is registered in the first stage and then in the output register.
// Throughput: one item per cycle while the output is not stalled, set by the
// line buffer, which reads and writes one entry for each item in the same cycle.
// Reset: position and window registers clear, row_width and row_count
// return to 64; the line buffer holds no defined data until written.
module marching_squares_tile_classifier import mstc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   // Tile input channel
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [CODE_W-1:0]      req_tile_code,
   input  logic                   req_frame_start,
   // Result channel
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [INDEX_W-1:0]     rsp_edge_index,
   output logic [COL_W-1:0]       rsp_out_col,
   output logic [ROW_W-1:0]       rsp_out_row,
   output logic                   rsp_frame_done,
   // Configuration port
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   logic [WIDTH_REG_W-1:0] row_width_ff;
   logic [COUNT_REG_W-1:0] row_count_ff;
   logic [WIDTH_REG_W-1:0] w_use;
   logic [COUNT_REG_W-1:0] h_use;

   logic [COL_W-1:0]       col_ff, col_in;
   logic [ROW_W-1:0]       row_ff, row_in;
   logic [COL_W-1:0]       cur_col;
   logic [ROW_W-1:0]       cur_row;
   logic [WIDTH_REG_W-1:0] col_next;
   logic [COUNT_REG_W-1:0] row_next;
   logic                   emit;
   logic                   last;

   logic                   advance;
   logic                   req_accept;

   logic                   valid_a_ff;
   logic                   emit_a_ff;
   logic                   last_a_ff;
   logic [CODE_W-1:0]      tile_a_ff;
   logic [COL_W-1:0]       col_a_ff;
   logic [ROW_W-1:0]       row_a_ff;
   logic [CODE_W-1:0]      above_a;

   logic [CODE_W-1:0]      cell_code [NUM_CELLS];
   acc_type                acc_chain [NUM_CELLS+1];

   logic                   rsp_valid_ff;
   logic [INDEX_W-1:0]     edge_index_ff;
   logic [COL_W-1:0]       out_col_ff;
   logic [ROW_W-1:0]       out_row_ff;
   logic                   frame_done_ff;

   // Configuration writes; the port never stalls.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff <= ROW_WIDTH_RESET;
         row_count_ff <= ROW_COUNT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_ROW_WIDTH: row_width_ff <= csr_data[WIDTH_REG_W-1:0];
            CSR_ROW_COUNT: row_count_ff <= csr_data[COUNT_REG_W-1:0];
            default: ;
         endcase
      end
   end

   // Register values in use, saturated into their ranges.
   always_comb begin
      w_use = row_width_ff;
      if (row_width_ff < WIDTH_REG_W'(3)) begin
         w_use = WIDTH_REG_W'(3);
      end else if (row_width_ff > WIDTH_REG_W'(MAX_ROW_WIDTH)) begin
         w_use = WIDTH_REG_W'(MAX_ROW_WIDTH);
      end
      h_use = row_count_ff;
      if (row_count_ff < COUNT_REG_W'(3)) begin
         h_use = COUNT_REG_W'(3);
      end else if (row_count_ff > COUNT_REG_W'(ROW_COUNT_MAX)) begin
         h_use = COUNT_REG_W'(ROW_COUNT_MAX);
      end
   end

   // Handshake: the whole pipeline moves when the output can take an item.
   assign advance    = !rsp_valid_ff || rsp_ready;
   assign req_ready  = advance;
   assign req_accept = req_valid && advance;

   // Position of the arriving tile and whether its window is emitted.
   always_comb begin
      cur_col  = req_frame_start ? '0 : col_ff;
      cur_row  = req_frame_start ? '0 : row_ff;
      col_next = {1'b0, cur_col} + WIDTH_REG_W'(1);
      row_next = {1'b0, cur_row} + COUNT_REG_W'(1);
      emit = (cur_col >= COL_W'(2)) && ({1'b0, cur_col} <= w_use - WIDTH_REG_W'(1))
          && (cur_row >= ROW_W'(2)) && ({1'b0, cur_row} <= h_use - COUNT_REG_W'(1));
      last = ({1'b0, cur_col} == w_use - WIDTH_REG_W'(1))
          && ({1'b0, cur_row} == h_use - COUNT_REG_W'(1));
      col_in = col_ff;
      row_in = row_ff;
      if (req_accept) begin
         if (col_next >= w_use) begin
            col_in = '0;
            row_in = (row_next >= h_use) ? '0 : row_next[ROW_W-1:0];
         end else begin
            col_in = col_next[COL_W-1:0];
            row_in = cur_row;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Line buffer: fetch the tile above, store the current tile.
   mstc_line_buffer u_line_buffer (
      .clock   (clock),
      .en      (req_accept),
      .addr    (cur_col),
      .wr_data (req_tile_code),
      .rd_data (above_a)
   );

   // First stage: the accepted item waits here for the line buffer data.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else if (advance) begin
         valid_a_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         tile_a_ff <= req_tile_code;
         emit_a_ff <= emit;
         last_a_ff <= last;
         col_a_ff  <= cur_col - COL_W'(1);
         row_a_ff  <= cur_row - ROW_W'(1);
      end
   end

   // Window chain: the top cell takes the tile above, the bottom the tile.
   assign cell_code[0] = above_a;
   assign cell_code[1] = tile_a_ff;
   assign acc_chain[0] = '0;

   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      mstc_corner_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (advance && valid_a_ff),
         .code_in  (cell_code[i]),
         .acc_in   (acc_chain[i]),
         .acc_out  (acc_chain[i+1])
      );
   end

   // Output register: holds a finished item until it is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= valid_a_ff && emit_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && valid_a_ff && emit_a_ff) begin
         edge_index_ff <= classify_index(acc_chain[NUM_CELLS]);
         out_col_ff    <= col_a_ff;
         out_row_ff    <= row_a_ff;
         frame_done_ff <= last_a_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_edge_index = edge_index_ff;
   assign rsp_out_col    = out_col_ff;
   assign rsp_out_row    = out_row_ff;
   assign rsp_frame_done = frame_done_ff;

   // A stalled output must hold the input side back.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("input taken while output is stalled");

   // An emitted window never has its top-left tile on the border.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_col != '0) && (rsp_out_row != '0))
      else $error("border window emitted");

   // A frame start places the next tile at column one of row zero.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_frame_start) |=> (col_ff == COL_W'(1))
         && (row_ff == '0))
      else $error("frame start did not restart the position");

endmodule
